// ----- sv/closest_value_search_int_assert.svh -----
// Assertion helpers for the closest value search block.
// Define ASSERT_OFF to compile the checks out.
`ifndef CLOSEST_VALUE_SEARCH_INT_ASSERT_SVH
`define CLOSEST_VALUE_SEARCH_INT_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequent checked in the same cycle as the antecedent.
`define CVS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CVS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define CVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/cvs_pkg.sv -----
`timescale 1ns / 1ps

package cvs_pkg;

  localparam int DATA_W      = 32;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_kind_t;

  // One classified operation waiting for the search engine.
  // operand is the load value or the query target.
  typedef struct packed {
    op_kind_t                  kind;
    logic [INDEX_W-1:0]        addr;
    logic signed [DATA_W-1:0]  operand;
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_MID,
    S_NBR,
    S_DONE
  } state_t;

endpackage

// ----- sv/cvs_if.sv -----
`timescale 1ns / 1ps

interface cvs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [cvs_pkg::INDEX_W-1:0]         entry_index;
  logic signed [cvs_pkg::DATA_W-1:0]   entry_value;
  logic signed [cvs_pkg::DATA_W-1:0]   target;

  modport source (output valid, command, entry_index, entry_value, target, input ready);
  modport sink   (input valid, command, entry_index, entry_value, target, output ready);
endinterface

interface cvs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvs_pkg::DATA_W-1:0]   closest_value;

  modport source (output valid, closest_value, input ready);
  modport sink   (input valid, closest_value, output ready);
endinterface

interface cvs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cvs_pkg::COUNT_W-1:0]         table_count;

  modport source (output valid, table_count, input ready);
  modport sink   (input valid, table_count, output ready);
endinterface

// ----- sv/cvs_ram.sv -----
`timescale 1ns / 1ps

module cvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/cvs_front.sv -----
`timescale 1ns / 1ps

module cvs_front #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  cvs_in_if.sink        items,
  output logic          op_valid,
  input  logic          op_ready,
  output cvs_pkg::op_t  op
);

  localparam int PTR_W  = (cvs_pkg::QUEUE_DEPTH > 1) ? $clog2(cvs_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(cvs_pkg::QUEUE_DEPTH + 1);

  cvs_pkg::op_t      slot [cvs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill;
  cvs_pkg::op_t      incoming;
  logic              in_range, keep, push, pop;

  // classify: loads past the table end are taken and dropped
  assign in_range = 32'(items.entry_index) < 32'(TABLE_DEPTH);
  assign incoming.kind    = cvs_pkg::op_kind_t'(items.command);
  assign incoming.addr    = items.entry_index;
  assign incoming.operand = (incoming.kind == cvs_pkg::OP_QUERY) ? items.target
                                                                : items.entry_value;
  assign keep = (incoming.kind == cvs_pkg::OP_QUERY) || in_range;

  assign items.ready = (fill != FILL_W'(cvs_pkg::QUEUE_DEPTH));
  assign push        = items.valid && items.ready && keep;
  assign op_valid    = (fill != '0);
  assign pop         = op_valid && op_ready;
  assign op          = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(cvs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(cvs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ----- sv/cvs_back.sv -----
`timescale 1ns / 1ps

module cvs_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cvs_pkg::COUNT_W-1:0]       table_count,
  input  logic                              op_valid,
  output logic                              op_ready,
  input  cvs_pkg::op_t                      op,
  output logic                              ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]    ram_waddr,
  output logic signed [cvs_pkg::DATA_W-1:0] ram_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0]    ram_raddr,
  input  logic signed [cvs_pkg::DATA_W-1:0] ram_rdata,
  cvs_out_if.source                         results
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WIDE_W = (CNT_W > cvs_pkg::COUNT_W) ? CNT_W : cvs_pkg::COUNT_W;
  localparam int DW     = cvs_pkg::DATA_W;

  cvs_pkg::state_t       state, state_next;
  logic signed [DW-1:0]  tgt, tgt_next, val, val_next, res, res_next;
  logic [CNT_W-1:0]      n, n_next, lo, lo_next, hi, hi_next;
  logic [IDX_W-1:0]      mid, mid_next;
  logic                  side, side_next;

  logic [WIDE_W-1:0]     cnt_wide, cnt_sat;
  logic [CNT_W-1:0]      mid_ext, mid_p1, upd_lo, upd_hi;
  logic [CNT_W:0]        upd_sum;
  logic [IDX_W-1:0]      upd_mid;
  logic signed [DW+1:0]  pair_sum, twice_t;
  logic signed [DW-1:0]  nearer;
  logic                  hit, t_lt, has_nbr, nbr_stop, go_low, loop_more, out_free, load_out;

  // active count: zero reads as one, saturate at the depth
  assign cnt_wide = WIDE_W'(table_count);
  always_comb begin
    cnt_sat = cnt_wide;
    if (cnt_wide == '0) begin
      cnt_sat = WIDE_W'(1);
    end else if (cnt_wide > WIDE_W'(TABLE_DEPTH)) begin
      cnt_sat = WIDE_W'(TABLE_DEPTH);
    end
  end

  // search decisions on the word just read
  assign mid_ext  = CNT_W'(mid);
  assign mid_p1   = mid_ext + CNT_W'(1);
  assign hit      = (ram_rdata == tgt);
  assign t_lt     = (tgt < ram_rdata);
  assign has_nbr  = t_lt ? (mid != '0) : (mid_p1 < n);
  assign nbr_stop = side ? (tgt > ram_rdata) : (tgt < ram_rdata);
  assign go_low   = (state == cvs_pkg::S_MID) ? t_lt : side;
  assign upd_lo   = go_low ? lo : mid_p1;
  assign upd_hi   = go_low ? mid_ext : hi;
  assign loop_more = (upd_lo < upd_hi);
  assign upd_sum  = {1'b0, upd_lo} + {1'b0, upd_hi};
  assign upd_mid  = IDX_W'(upd_sum >> 1);

  // t - lower >= upper - t  <=>  2t >= lower + upper; tie picks upper
  assign pair_sum = (DW+2)'(ram_rdata) + (DW+2)'(val);
  assign twice_t  = $signed({tgt[DW-1], tgt, 1'b0});
  assign nearer   = (twice_t >= pair_sum) ? (side ? val : ram_rdata)
                                          : (side ? ram_rdata : val);

  assign out_free = !results.valid || results.ready;
  assign load_out = (state == cvs_pkg::S_DONE) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      cvs_pkg::S_IDLE: begin
        if (op_valid && op.kind == cvs_pkg::OP_QUERY) begin
          state_next = cvs_pkg::S_FIRST;
        end
      end
      cvs_pkg::S_FIRST: begin
        state_next = (tgt <= ram_rdata) ? cvs_pkg::S_DONE : cvs_pkg::S_LAST;
      end
      cvs_pkg::S_LAST: begin
        state_next = (tgt >= ram_rdata) ? cvs_pkg::S_DONE : cvs_pkg::S_MID;
      end
      cvs_pkg::S_MID: begin
        if (hit) begin
          state_next = cvs_pkg::S_DONE;
        end else if (has_nbr) begin
          state_next = cvs_pkg::S_NBR;
        end else begin
          state_next = loop_more ? cvs_pkg::S_MID : cvs_pkg::S_DONE;
        end
      end
      cvs_pkg::S_NBR: begin
        if (nbr_stop) begin
          state_next = cvs_pkg::S_DONE;
        end else begin
          state_next = loop_more ? cvs_pkg::S_MID : cvs_pkg::S_DONE;
        end
      end
      cvs_pkg::S_DONE: begin
        if (out_free) begin
          state_next = cvs_pkg::S_IDLE;
        end
      end
      default: state_next = cvs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_ready   = (state == cvs_pkg::S_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = IDX_W'(op.addr);
    ram_wdata  = op.operand;
    ram_raddr  = mid;
    tgt_next   = tgt;
    n_next     = n;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    val_next   = val;
    side_next  = side;
    res_next   = res;
    case (state)
      cvs_pkg::S_IDLE: begin
        if (op_valid) begin
          if (op.kind == cvs_pkg::OP_LOAD) begin
            ram_we = 1'b1;
          end else begin
            tgt_next  = op.operand;
            n_next    = CNT_W'(cnt_sat);
            ram_raddr = '0;
          end
        end
      end
      cvs_pkg::S_FIRST: begin
        if (tgt <= ram_rdata) begin
          res_next = ram_rdata;
        end else begin
          ram_raddr = IDX_W'(n - CNT_W'(1));
        end
      end
      cvs_pkg::S_LAST: begin
        if (tgt >= ram_rdata) begin
          res_next = ram_rdata;
        end else begin
          lo_next   = '0;
          hi_next   = n;
          mid_next  = IDX_W'(n >> 1);
          ram_raddr = IDX_W'(n >> 1);
        end
      end
      cvs_pkg::S_MID: begin
        val_next  = ram_rdata;
        side_next = t_lt;
        if (hit) begin
          res_next = ram_rdata;
        end else if (has_nbr) begin
          ram_raddr = t_lt ? (mid - IDX_W'(1)) : IDX_W'(mid_p1);
        end else if (loop_more) begin
          lo_next   = upd_lo;
          hi_next   = upd_hi;
          mid_next  = upd_mid;
          ram_raddr = upd_mid;
        end else begin
          res_next = ram_rdata;
        end
      end
      cvs_pkg::S_NBR: begin
        if (nbr_stop) begin
          res_next = nearer;
        end else if (loop_more) begin
          lo_next   = upd_lo;
          hi_next   = upd_hi;
          mid_next  = upd_mid;
          ram_raddr = upd_mid;
        end else begin
          res_next = val;
        end
      end
      cvs_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cvs_pkg::S_IDLE;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt  <= tgt_next;
    n    <= n_next;
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    val  <= val_next;
    side <= side_next;
    res  <= res_next;
    if (load_out) begin
      results.closest_value <= res;
    end
  end

endmodule

// ----- sv/closest_value_search_int.sv -----
// Closest value search over a sorted table of signed 32-bit words. Load beats
// (command 0) write one table word and give no result; a load at an index
// past the table end is taken and dropped. Query beats (command 1) return the
// in-use entry nearest the target, ties toward the larger entry, with the
// first entry for targets at or below it and the last in-use entry for
// targets at or above that. A query whose target falls outside the table ends
// after reading the first word, or the first and last words; otherwise it runs
// a binary search through the single read port of the table RAM, one word per
// cycle. A two-beat queue parts the input side from the search engine, and a
// result register parts the engine from the output; a stalled output holds
// the engine once its next result is ready, and a full queue stalls the input.
// Table words are not cleared after reset and must be loaded before a query
// reaches them. table_count is to be written over its own channel only while
// the block is idle; the block does not enforce this. Zero acts as one and
// values above the depth saturate.
`timescale 1ns / 1ps

`include "closest_value_search_int_assert.svh"

module closest_value_search_int #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  cvs_in_if.sink    items,
  cvs_out_if.source results,
  cvs_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [cvs_pkg::COUNT_W-1:0]       table_count;
  logic                              op_valid, op_ready;
  cvs_pkg::op_t                      op;

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr, ram_raddr;
  logic signed [cvs_pkg::DATA_W-1:0] ram_wdata, ram_rdata;
  logic [cvs_pkg::DATA_W-1:0]        ram_q;

  // config register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= cvs_pkg::COUNT_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      table_count <= cfg.table_count;
    end
  end

  // front: take beats, classify, queue
  cvs_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  // table storage, registered read
  cvs_ram #(
    .WIDTH (cvs_pkg::DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign ram_rdata = $signed(ram_q);

  // back: loads and binary search, result register
  cvs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .table_count (table_count),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op          (op),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .results     (results)
  );

  // a query pop moves the engine off idle
  `CVS_ASSERT_NEXT(a_query_busy, clk, rst, op_valid && op_ready && op.kind == cvs_pkg::OP_QUERY, !op_ready, "engine still ready after query pop")
  // a load completes in its pop cycle
  `CVS_ASSERT_NEXT(a_load_one_cycle, clk, rst, op_valid && op_ready && op.kind == cvs_pkg::OP_LOAD, op_ready, "engine busy after load pop")
  // a new result only comes out of a finished search
  `CVS_ASSERT_SAME(a_result_from_search, clk, rst, $rose(results.valid), $past(!op_ready), "result raised while engine idle")

endmodule
